### rtl/tlsm_pkg.sv
// Shared types, codes and reset values for the target lock state machine.
package tlsm_pkg;

    typedef enum logic [2:0] {
        MODE_LOST      = 3'd0,
        MODE_DETECTING = 3'd1,
        MODE_TRACKING  = 3'd2,
        MODE_COASTING  = 3'd3,
        MODE_SWITCHING = 3'd4
    } mode_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOST_TIMEOUT   = 3'd0,
        CFG_MIN_DETECT     = 3'd1,
        CFG_NORMAL_LIMIT   = 3'd2,
        CFG_OUTPOST_LIMIT  = 3'd3,
        CFG_SWITCH_TIMEOUT = 3'd4,
        CFG_OUTPOST_CLASS  = 3'd5
    } cfg_idx_t;

    localparam logic [15:0] RST_LOST_TIMEOUT   = 16'd100;
    localparam logic [7:0]  RST_MIN_DETECT     = 8'd5;
    localparam logic [7:0]  RST_NORMAL_LIMIT   = 8'd20;
    localparam logic [7:0]  RST_OUTPOST_LIMIT  = 8'd60;
    localparam logic [7:0]  RST_SWITCH_TIMEOUT = 8'd200;
    localparam logic [3:0]  RST_OUTPOST_CLASS  = 4'd6;
    localparam logic [2:0]  RST_PRIORITY       = 3'd5;

    typedef struct packed {
        logic [15:0] lost_timeout_ms;
        logic [7:0]  min_detect_frames;
        logic [7:0]  normal_lost_limit;
        logic [7:0]  outpost_lost_limit;
        logic [7:0]  switch_timeout_frames;
        logic [3:0]  outpost_class_code;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        mode_t       prior_mode;
        logic [7:0]  detect_cnt;
        logic [7:0]  miss_cnt;
        logic [3:0]  locked_class;
        logic        locked_size;
        logic [2:0]  locked_priority;
        logic [2:0]  wanted_priority;
    } track_st_t;

    typedef struct packed {
        logic [15:0]        frame_interval_ms;
        logic               main_any;
        logic [2:0]         main_best_priority;
        logic [3:0]         main_best_class;
        logic               main_best_size;
        logic               main_match;
        logic               side_any;
        logic [2:0]         side_best_priority;
        logic signed [15:0] side_delta_yaw;
        logic signed [15:0] side_delta_pitch;
        logic               filter_converged;
        logic               filter_diverged;
    } frame_item_t;

    typedef struct packed {
        logic [2:0]         track_state;
        logic               target_valid;
        logic [3:0]         locked_class_out;
        logic               locked_size_out;
        logic [2:0]         locked_priority_out;
        logic               reinit_target;
        logic               switch_request;
        logic signed [15:0] switch_delta_yaw;
        logic signed [15:0] switch_delta_pitch;
    } track_res_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == 8'hFF) ? 8'hFF : c + 8'd1;
    endfunction

endpackage

### rtl/tlsm_if.sv
// Valid/ready channel interfaces for frame summaries and track results.
interface tlsm_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        frame_interval_ms;
    logic               main_any;
    logic [2:0]         main_best_priority;
    logic [3:0]         main_best_class;
    logic               main_best_size;
    logic               main_match;
    logic               side_any;
    logic [2:0]         side_best_priority;
    logic signed [15:0] side_delta_yaw;
    logic signed [15:0] side_delta_pitch;
    logic               filter_converged;
    logic               filter_diverged;

    modport source (
        output valid, frame_interval_ms, main_any, main_best_priority, main_best_class,
               main_best_size, main_match, side_any, side_best_priority, side_delta_yaw,
               side_delta_pitch, filter_converged, filter_diverged,
        input  ready
    );
    modport sink (
        input  valid, frame_interval_ms, main_any, main_best_priority, main_best_class,
               main_best_size, main_match, side_any, side_best_priority, side_delta_yaw,
               side_delta_pitch, filter_converged, filter_diverged,
        output ready
    );
endinterface

interface tlsm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         track_state;
    logic               target_valid;
    logic [3:0]         locked_class_out;
    logic               locked_size_out;
    logic [2:0]         locked_priority_out;
    logic               reinit_target;
    logic               switch_request;
    logic signed [15:0] switch_delta_yaw;
    logic signed [15:0] switch_delta_pitch;

    modport source (
        output valid, track_state, target_valid, locked_class_out, locked_size_out,
               locked_priority_out, reinit_target, switch_request, switch_delta_yaw,
               switch_delta_pitch,
        input  ready
    );
    modport sink (
        input  valid, track_state, target_valid, locked_class_out, locked_size_out,
               locked_priority_out, reinit_target, switch_request, switch_delta_yaw,
               switch_delta_pitch,
        output ready
    );
endinterface

### rtl/tlsm_cfg_regs.sv
// Configuration register file with write-only access.
module tlsm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tlsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tlsm_pkg::cfg_t                   cfg
);

    tlsm_pkg::cfg_t cfg_reg;
    tlsm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tlsm_pkg::cfg_idx_t'(cfg_index))
                tlsm_pkg::CFG_LOST_TIMEOUT:   cfg_next.lost_timeout_ms       = cfg_wdata;
                tlsm_pkg::CFG_MIN_DETECT:     cfg_next.min_detect_frames     = cfg_wdata[7:0];
                tlsm_pkg::CFG_NORMAL_LIMIT:   cfg_next.normal_lost_limit     = cfg_wdata[7:0];
                tlsm_pkg::CFG_OUTPOST_LIMIT:  cfg_next.outpost_lost_limit    = cfg_wdata[7:0];
                tlsm_pkg::CFG_SWITCH_TIMEOUT: cfg_next.switch_timeout_frames = cfg_wdata[7:0];
                tlsm_pkg::CFG_OUTPOST_CLASS:  cfg_next.outpost_class_code    = cfg_wdata[3:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_timeout_ms       <= tlsm_pkg::RST_LOST_TIMEOUT;
            cfg_reg.min_detect_frames     <= tlsm_pkg::RST_MIN_DETECT;
            cfg_reg.normal_lost_limit     <= tlsm_pkg::RST_NORMAL_LIMIT;
            cfg_reg.outpost_lost_limit    <= tlsm_pkg::RST_OUTPOST_LIMIT;
            cfg_reg.switch_timeout_frames <= tlsm_pkg::RST_SWITCH_TIMEOUT;
            cfg_reg.outpost_class_code    <= tlsm_pkg::RST_OUTPOST_CLASS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/tlsm_step.sv
// Per-frame next-state and result logic of the track state machine.
module tlsm_step (
    input  tlsm_pkg::cfg_t        cfg,
    input  tlsm_pkg::track_st_t   st,
    input  tlsm_pkg::frame_item_t item,
    output tlsm_pkg::track_st_t   st_next,
    output tlsm_pkg::track_res_t  res
);

    always_comb
    begin
        tlsm_pkg::track_st_t nxt;
        tlsm_pkg::mode_t     m_sel;
        tlsm_pkg::mode_t     m_run;
        logic                found;
        logic                take_main;
        logic                sw;
        logic [7:0]          cnt;
        logic [7:0]          limit;

        nxt       = st;
        found     = 1'b0;
        take_main = 1'b0;
        sw        = 1'b0;
        cnt       = 8'd0;
        limit     = 8'd0;

        // Frame-gap timeout drops any live track.
        m_sel = st.mode;
        if (st.mode != tlsm_pkg::MODE_LOST && item.frame_interval_ms > cfg.lost_timeout_ms)
            m_sel = tlsm_pkg::MODE_LOST;

        priority if (m_sel == tlsm_pkg::MODE_LOST)
        begin
            found     = item.main_any;
            take_main = item.main_any;
        end
        else if (m_sel == tlsm_pkg::MODE_TRACKING && item.main_any &&
                 item.main_best_priority < st.locked_priority)
        begin
            found     = 1'b1;
            take_main = 1'b1;
        end
        else if (m_sel == tlsm_pkg::MODE_TRACKING && item.side_any &&
                 item.side_best_priority < st.locked_priority && item.filter_converged)
        begin
            m_sel               = tlsm_pkg::MODE_SWITCHING;
            nxt.wanted_priority = item.side_best_priority;
            sw                  = 1'b1;
        end
        else if (m_sel == tlsm_pkg::MODE_SWITCHING)
        begin
            found = item.main_any && (item.main_best_priority == st.wanted_priority);
        end
        else if (m_sel == tlsm_pkg::MODE_DETECTING && st.prior_mode == tlsm_pkg::MODE_SWITCHING)
        begin
            found     = item.main_any;
            take_main = item.main_any;
        end
        else
        begin
            found = item.main_match;
        end

        if (take_main)
        begin
            nxt.locked_class    = item.main_best_class;
            nxt.locked_size     = item.main_best_size;
            nxt.locked_priority = item.main_best_priority;
        end

        nxt.prior_mode = m_sel;
        limit = (nxt.locked_class == cfg.outpost_class_code) ? cfg.outpost_lost_limit
                                                             : cfg.normal_lost_limit;
        m_run = m_sel;

        unique case (m_sel)
            tlsm_pkg::MODE_LOST:
            begin
                if (found)
                begin
                    m_run          = tlsm_pkg::MODE_DETECTING;
                    nxt.detect_cnt = 8'd1;
                end
            end
            tlsm_pkg::MODE_DETECTING:
            begin
                if (found)
                begin
                    cnt            = tlsm_pkg::sat_inc(st.detect_cnt);
                    nxt.detect_cnt = cnt;
                    if (cnt >= cfg.min_detect_frames)
                        m_run = tlsm_pkg::MODE_TRACKING;
                end
                else
                begin
                    nxt.detect_cnt = 8'd0;
                    m_run          = tlsm_pkg::MODE_LOST;
                end
            end
            tlsm_pkg::MODE_TRACKING:
            begin
                if (!found)
                begin
                    nxt.miss_cnt = 8'd1;
                    m_run        = tlsm_pkg::MODE_COASTING;
                end
            end
            tlsm_pkg::MODE_SWITCHING:
            begin
                if (found)
                    m_run = tlsm_pkg::MODE_DETECTING;
                else
                begin
                    cnt          = tlsm_pkg::sat_inc(st.miss_cnt);
                    nxt.miss_cnt = cnt;
                    if (cnt > cfg.switch_timeout_frames)
                        m_run = tlsm_pkg::MODE_LOST;
                end
            end
            tlsm_pkg::MODE_COASTING:
            begin
                if (found)
                    m_run = tlsm_pkg::MODE_TRACKING;
                else
                begin
                    cnt          = tlsm_pkg::sat_inc(st.miss_cnt);
                    nxt.miss_cnt = cnt;
                    if (cnt > limit)
                        m_run = tlsm_pkg::MODE_LOST;
                end
            end
            default:
                m_run = tlsm_pkg::MODE_LOST;
        endcase

        // Divergence drops the track after the transitions.
        if (m_run != tlsm_pkg::MODE_LOST && item.filter_diverged)
            m_run = tlsm_pkg::MODE_LOST;

        nxt.mode = m_run;
        st_next  = nxt;

        res.track_state         = m_run;
        res.target_valid        = (m_run != tlsm_pkg::MODE_LOST);
        res.locked_class_out    = nxt.locked_class;
        res.locked_size_out     = nxt.locked_size;
        res.locked_priority_out = nxt.locked_priority;
        res.reinit_target       = take_main;
        res.switch_request      = sw;
        res.switch_delta_yaw    = sw ? item.side_delta_yaw : 16'sd0;
        res.switch_delta_pitch  = sw ? item.side_delta_pitch : 16'sd0;
    end

endmodule

### rtl/target_lock_state_machine_core.sv
// Top level of the target lock state machine: input, state and result registers.
// Takes one frame summary per cycle while the output is not stalled and returns one
// result per summary. A summary sits in the input register while the state machine
// logic computes the next track state and the result; both are registered together,
// so the result passes from the input register through the result register to the
// output channel; a new summary can follow in every cycle unless the output stalls.
// The input and result registers separate the two channels, so a stalled result does
// not stop an input transfer while the input register is free. Configuration writes
// take effect on the next cycle and are meant for idle periods only.
module target_lock_state_machine_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tlsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    tlsm_in_if.sink                          in_ch,
    tlsm_out_if.source                       out_ch
);

    tlsm_pkg::cfg_t        cfg;
    tlsm_pkg::frame_item_t item_reg;
    logic                  item_valid_reg;
    tlsm_pkg::track_st_t   st_reg;
    tlsm_pkg::track_st_t   st_next;
    tlsm_pkg::track_res_t  res_reg;
    tlsm_pkg::track_res_t  res_next;
    logic                  res_valid_reg;
    logic                  advance;
    logic                  in_xfer;

    tlsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tlsm_step u_step (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Advance when the held item can move into a free or draining result register.
    assign advance     = item_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !item_valid_reg || advance;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ch.ready)
            item_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.frame_interval_ms  <= in_ch.frame_interval_ms;
            item_reg.main_any           <= in_ch.main_any;
            item_reg.main_best_priority <= in_ch.main_best_priority;
            item_reg.main_best_class    <= in_ch.main_best_class;
            item_reg.main_best_size     <= in_ch.main_best_size;
            item_reg.main_match         <= in_ch.main_match;
            item_reg.side_any           <= in_ch.side_any;
            item_reg.side_best_priority <= in_ch.side_best_priority;
            item_reg.side_delta_yaw     <= in_ch.side_delta_yaw;
            item_reg.side_delta_pitch   <= in_ch.side_delta_pitch;
            item_reg.filter_converged   <= in_ch.filter_converged;
            item_reg.filter_diverged    <= in_ch.filter_diverged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode            <= tlsm_pkg::MODE_LOST;
            st_reg.prior_mode      <= tlsm_pkg::MODE_LOST;
            st_reg.detect_cnt      <= 8'd0;
            st_reg.miss_cnt        <= 8'd0;
            st_reg.locked_class    <= 4'd0;
            st_reg.locked_size     <= 1'b0;
            st_reg.locked_priority <= tlsm_pkg::RST_PRIORITY;
            st_reg.wanted_priority <= tlsm_pkg::RST_PRIORITY;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (out_ch.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid               = res_valid_reg;
    assign out_ch.track_state         = res_reg.track_state;
    assign out_ch.target_valid        = res_reg.target_valid;
    assign out_ch.locked_class_out    = res_reg.locked_class_out;
    assign out_ch.locked_size_out     = res_reg.locked_size_out;
    assign out_ch.locked_priority_out = res_reg.locked_priority_out;
    assign out_ch.reinit_target       = res_reg.reinit_target;
    assign out_ch.switch_request      = res_reg.switch_request;
    assign out_ch.switch_delta_yaw    = res_reg.switch_delta_yaw;
    assign out_ch.switch_delta_pitch  = res_reg.switch_delta_pitch;

endmodule

### rtl/tlsm_checker.sv
// Port-level assertions for the target lock state machine, bound to the top level.
module tlsm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         track_state,
    input logic               target_valid,
    input logic               reinit_target,
    input logic               switch_request,
    input logic signed [15:0] switch_delta_yaw,
    input logic signed [15:0] switch_delta_pitch
);

    // Target reported exactly when the track is live.
    a_valid_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (target_valid == (track_state != tlsm_pkg::MODE_LOST)))
        else $error("target_valid disagrees with track_state");

    // Offsets stay zero without a switch request.
    a_delta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !switch_request) |->
            (switch_delta_yaw == 16'sd0 && switch_delta_pitch == 16'sd0))
        else $error("switch offsets nonzero without request");

    // A switch request leaves the track switching or dropped.
    a_switch_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && switch_request) |->
            (track_state == tlsm_pkg::MODE_SWITCHING || track_state == tlsm_pkg::MODE_LOST))
        else $error("switch request with wrong track_state");

    // A new target never lands in a miss phase.
    a_reinit_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reinit_target) |->
            (track_state == tlsm_pkg::MODE_LOST || track_state == tlsm_pkg::MODE_DETECTING ||
             track_state == tlsm_pkg::MODE_TRACKING))
        else $error("reinit_target with wrong track_state");

    // Hold a stalled result.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(track_state) &&
            $stable(switch_request) && $stable(reinit_target)))
        else $error("stalled result changed");

endmodule

bind target_lock_state_machine_core tlsm_checker u_tlsm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .track_state        (out_ch.track_state),
    .target_valid       (out_ch.target_valid),
    .reinit_target      (out_ch.reinit_target),
    .switch_request     (out_ch.switch_request),
    .switch_delta_yaw   (out_ch.switch_delta_yaw),
    .switch_delta_pitch (out_ch.switch_delta_pitch)
);
